// ===== design/lis_pkg.sv =====
package lis_pkg;

  localparam int PC_W  = 6;
  localparam int DIV_W = 32;

  // Request commands.
  localparam logic [1:0] CMD_BLOCK   = 2'd0;
  localparam logic [1:0] CMD_CHUNKED = 2'd1;
  localparam logic [1:0] CMD_DYNAMIC = 2'd2;
  localparam logic [1:0] CMD_GUIDED  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_NO_RANGE = 2'd3;

  typedef enum logic [4:0] {
    OP_LOAD,
    OP_SETUP,
    OP_NOP,
    OP_DIV_SPAN_N,
    OP_DIV_SPAN_CH,
    OP_DIV_CNT,
    OP_DIV_RUN,
    OP_BLK_MUL,
    OP_BLK_BEG,
    OP_BLK_END,
    OP_NO_RANGE,
    OP_EMIT,
    OP_CH_TOTAL,
    OP_CH_CNT,
    OP_CH_RANGE,
    OP_ZERO_CHUNK,
    OP_DYN_BEG,
    OP_DYN_SIZE,
    OP_GD_SIZE,
    OP_DYN_FIN
  } op_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_DYN,
    C_GUIDED,
    C_BAD_RANK,
    C_CHUNKED,
    C_CHUNK_ZERO,
    C_K_GE_TOTAL,
    C_SPAN_NONPOS,
    C_MORE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_full;
    logic dyn;
    logic guided;
    logic bad_rank;
    logic chunked;
    logic chunk_zero;
    logic k_ge_total;
    logic span_nonpos;
    logic more;
  } flags_t;

  // Entry points of the microprogram.
  localparam logic [PC_W-1:0] L_FETCH    = 6'd0;
  localparam logic [PC_W-1:0] L_NO_RANGE = 6'd10;
  localparam logic [PC_W-1:0] L_CHUNKED  = 6'd12;
  localparam logic [PC_W-1:0] L_RANGE    = 6'd20;
  localparam logic [PC_W-1:0] L_ZERO     = 6'd23;
  localparam logic [PC_W-1:0] L_DYN      = 6'd25;
  localparam logic [PC_W-1:0] L_DYN_SIZE = 6'd26;
  localparam logic [PC_W-1:0] L_GUIDED   = 6'd27;
  localparam logic [PC_W-1:0] L_DYN_FIN  = 6'd31;

  function automatic ctl_t cw(op_t op, cond_t cond, logic [PC_W-1:0] target);
    ctl_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ctl_t rom_word(logic [PC_W-1:0] pc);
    ctl_t w;
    unique case (pc)
      6'd0:  w = cw(OP_LOAD,        C_NONE,        L_FETCH);
      6'd1:  w = cw(OP_SETUP,       C_DYN,         L_DYN);
      6'd2:  w = cw(OP_NOP,         C_BAD_RANK,    L_NO_RANGE);
      6'd3:  w = cw(OP_NOP,         C_CHUNKED,     L_CHUNKED);
      6'd4:  w = cw(OP_DIV_SPAN_N,  C_NONE,        L_FETCH);
      6'd5:  w = cw(OP_DIV_RUN,     C_NONE,        L_FETCH);
      6'd6:  w = cw(OP_BLK_MUL,     C_NONE,        L_FETCH);
      6'd7:  w = cw(OP_BLK_BEG,     C_NONE,        L_FETCH);
      6'd8:  w = cw(OP_BLK_END,     C_NONE,        L_FETCH);
      6'd9:  w = cw(OP_EMIT,        C_ALWAYS,      L_FETCH);
      6'd10: w = cw(OP_NO_RANGE,    C_NONE,        L_FETCH);
      6'd11: w = cw(OP_EMIT,        C_ALWAYS,      L_FETCH);
      6'd12: w = cw(OP_NOP,         C_CHUNK_ZERO,  L_ZERO);
      6'd13: w = cw(OP_DIV_SPAN_CH, C_NONE,        L_FETCH);
      6'd14: w = cw(OP_DIV_RUN,     C_NONE,        L_FETCH);
      6'd15: w = cw(OP_CH_TOTAL,    C_NONE,        L_FETCH);
      6'd16: w = cw(OP_NOP,         C_K_GE_TOTAL,  L_NO_RANGE);
      6'd17: w = cw(OP_DIV_CNT,     C_NONE,        L_FETCH);
      6'd18: w = cw(OP_DIV_RUN,     C_NONE,        L_FETCH);
      6'd19: w = cw(OP_CH_CNT,      C_NONE,        L_FETCH);
      6'd20: w = cw(OP_CH_RANGE,    C_NONE,        L_FETCH);
      6'd21: w = cw(OP_EMIT,        C_MORE,        L_RANGE);
      6'd22: w = cw(OP_NOP,         C_ALWAYS,      L_FETCH);
      6'd23: w = cw(OP_ZERO_CHUNK,  C_NONE,        L_FETCH);
      6'd24: w = cw(OP_EMIT,        C_ALWAYS,      L_FETCH);
      6'd25: w = cw(OP_DYN_BEG,     C_GUIDED,      L_GUIDED);
      6'd26: w = cw(OP_DYN_SIZE,    C_ALWAYS,      L_DYN_FIN);
      6'd27: w = cw(OP_NOP,         C_SPAN_NONPOS, L_DYN_SIZE);
      6'd28: w = cw(OP_DIV_SPAN_N,  C_NONE,        L_FETCH);
      6'd29: w = cw(OP_DIV_RUN,     C_NONE,        L_FETCH);
      6'd30: w = cw(OP_GD_SIZE,     C_NONE,        L_FETCH);
      6'd31: w = cw(OP_DYN_FIN,     C_NONE,        L_FETCH);
      6'd32: w = cw(OP_EMIT,        C_ALWAYS,      L_FETCH);
      default: w = cw(OP_NOP,       C_ALWAYS,      L_FETCH);
    endcase
    return w;
  endfunction

endpackage

// ===== design/lis_div.sv =====
// Restoring divider, one quotient bit per cycle.
module lis_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lis_pkg::DIV_W-1:0]      dividend,
  input  logic [lis_pkg::DIV_W-2:0]      divisor,
  output logic                           busy,
  output logic [lis_pkg::DIV_W-1:0]      quotient,
  output logic [lis_pkg::DIV_W-1:0]      remainder
);

  localparam int W   = lis_pkg::DIV_W;
  localparam int CW  = $clog2(W);

  logic [CW-1:0] count;
  logic [W-2:0]  dsr;
  logic [W-1:0]  trial;
  logic          take;

  assign trial = {remainder[W-2:0], quotient[W-1]};
  assign take  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CW'(W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      remainder <= take ? (trial - {1'b0, dsr}) : trial;
      quotient  <= {quotient[W-2:0], take};
    end
  end

endmodule

// ===== design/lis_seq.sv =====
// Step counter and control store of the microprogram.
module lis_seq (
  input  logic            clk,
  input  logic            rst,
  input  lis_pkg::flags_t flags,
  output lis_pkg::ctl_t   ctl
);

  logic [lis_pkg::PC_W-1:0] pc;
  logic                     hold;
  logic                     taken;

  assign ctl = lis_pkg::rom_word(pc);

  always_comb begin
    unique case (ctl.op)
      lis_pkg::OP_LOAD:    hold = !flags.in_valid;
      lis_pkg::OP_DIV_RUN: hold = flags.div_busy;
      lis_pkg::OP_EMIT:    hold = flags.out_full;
      default:             hold = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctl.cond)
      lis_pkg::C_ALWAYS:      taken = 1'b1;
      lis_pkg::C_DYN:         taken = flags.dyn;
      lis_pkg::C_GUIDED:      taken = flags.guided;
      lis_pkg::C_BAD_RANK:    taken = flags.bad_rank;
      lis_pkg::C_CHUNKED:     taken = flags.chunked;
      lis_pkg::C_CHUNK_ZERO:  taken = flags.chunk_zero;
      lis_pkg::C_K_GE_TOTAL:  taken = flags.k_ge_total;
      lis_pkg::C_SPAN_NONPOS: taken = flags.span_nonpos;
      lis_pkg::C_MORE:        taken = flags.more;
      default:                taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lis_pkg::L_FETCH;
    end else if (!hold) begin
      pc <= taken ? ctl.target : pc + 1'b1;
    end
  end

endmodule

// ===== design/loop_iteration_scheduler_top.sv =====
// Loop iteration scheduler, driven by a microprogram of 33 steps.
// Dynamic requests do not use the divider; static block and guided requests run the
// serial divider at most once. Static chunked requests run it at most twice before the
// first range, then emit each further range without it. One request is in flight at a time.
// Synchronous active-high reset clears the step counter, the shared index, the output
// valid flag and the divider, and sets the worker count to one.
module loop_iteration_scheduler_top #(
  parameter int MAX_WORKERS = 64,
  parameter int MAX_RANGES  = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [6:0]         worker_rank,
  input  logic signed [31:0] loop_first,
  input  logic signed [31:0] loop_limit,
  input  logic [30:0]        chunk_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] range_begin,
  output logic signed [31:0] range_end,
  output logic               last_range,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  localparam int          CNT_W  = $clog2(MAX_RANGES + 1);
  localparam logic [10:0] MAXW_L = 11'(MAX_WORKERS);

  lis_pkg::ctl_t   ctl;
  lis_pkg::flags_t flags;

  // Configuration register. Writes must be made only while the block is idle; the block itself does not enforce this.
  logic [6:0] worker_count;
  logic [6:0] n_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= 7'd1;
    end else if (cfg_valid) begin
      worker_count <= cfg_data;
    end
  end

  // A count of zero is taken as one, and anything above the maximum as the maximum.
  always_comb begin
    priority if (worker_count == 7'd0) begin
      n_eff = 7'd1;
    end else if ({4'b0, worker_count} > MAXW_L) begin
      n_eff = MAXW_L[6:0];
    end else begin
      n_eff = worker_count;
    end
  end

  // Request registers, loaded by the fetch step.
  logic [1:0]  cmd_r;
  logic [6:0]  rank_r;
  logic [31:0] first_r;
  logic [31:0] limit_r;
  logic [30:0] chunk_r;

  // Working registers.
  logic [31:0]      idx;        // shared index for dynamic and guided requests
  logic [32:0]      span;       // loop length, or limit minus index, two's complement
  logic [31:0]      prod;
  logic [32:0]      total;
  logic [39:0]      off;        // offset of the current chunk from loop_first
  logic [37:0]      stepv;      // distance between two chunks of one rank
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       st_r;
  logic [31:0]      beg_r;
  logic [31:0]      size_r;
  logic [31:0]      res_beg;
  logic [31:0]      res_end;
  logic             res_last;
  logic [1:0]       res_stat;

  // Divider and its operand selection.
  logic        div_start;
  logic [31:0] div_dividend;
  logic [30:0] div_divisor;
  logic        div_busy;
  logic [31:0] q;
  logic [31:0] rem;

  logic [6:0]  r0;
  logic        r0_lt;
  logic [31:0] r0_min;
  logic [38:0] blk_prod_w;
  logic [32:0] diff_w;
  logic [32:0] cnt_w;
  logic [39:0] end_off;
  logic [33:0] dyn_end;
  logic        out_full;

  assign r0         = rank_r - 7'd1;
  assign r0_lt      = {25'b0, r0} < rem;
  assign r0_min     = r0_lt ? {25'b0, r0} : rem;
  assign blk_prod_w = {7'b0, q} * {32'b0, r0};
  assign diff_w     = {limit_r[31], limit_r} - {first_r[31], first_r};
  assign cnt_w      = {1'b0, q} + 33'd1;
  assign end_off    = off + {9'b0, chunk_r};
  assign dyn_end    = {{2{beg_r[31]}}, beg_r} + {2'b0, size_r};
  assign out_full   = out_valid && !out_ready;

  assign div_start = (ctl.op == lis_pkg::OP_DIV_SPAN_N) || (ctl.op == lis_pkg::OP_DIV_SPAN_CH)
                  || (ctl.op == lis_pkg::OP_DIV_CNT);

  always_comb begin
    unique case (ctl.op)
      lis_pkg::OP_DIV_SPAN_CH: begin
        div_dividend = span[31:0];
        div_divisor  = chunk_r;
      end
      lis_pkg::OP_DIV_CNT: begin
        // Chunks left after this rank's first, shared out over the ranks.
        div_dividend = total[31:0] - 32'd1 - {25'b0, r0};
        div_divisor  = {24'b0, n_eff};
      end
      default: begin
        div_dividend = span[31:0];
        div_divisor  = {24'b0, n_eff};
      end
    endcase
  end

  lis_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (q),
    .remainder (rem)
  );

  // Flags for the sequencer's holds and conditional jumps.
  always_comb begin
    flags.in_valid    = in_valid;
    flags.div_busy    = div_busy;
    flags.out_full    = out_full;
    flags.dyn         = cmd_r[1];
    flags.guided      = cmd_r == lis_pkg::CMD_GUIDED;
    flags.chunked     = cmd_r == lis_pkg::CMD_CHUNKED;
    flags.bad_rank    = (rank_r == 7'd0) || (rank_r > n_eff);
    flags.chunk_zero  = chunk_r == 31'd0;
    flags.k_ge_total  = {26'b0, r0} >= total;
    flags.span_nonpos = span[32] || (span == 33'd0);
    flags.more        = cnt_r != '0;
  end

  lis_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  assign in_ready = ctl.op == lis_pkg::OP_LOAD;

  // The shared index is the only datapath state that survives between requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.op == lis_pkg::OP_DYN_FIN) begin
      idx <= idx + size_r;
    end
  end

  // Datapath: each control word selects one register transfer.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      lis_pkg::OP_LOAD: begin
        if (in_valid) begin
          cmd_r   <= command;
          rank_r  <= worker_rank;
          first_r <= loop_first;
          limit_r <= loop_limit;
          chunk_r <= chunk_size;
        end
      end
      lis_pkg::OP_SETUP: begin
        // A reversed loop counts as empty.
        span <= diff_w[32] ? 33'd0 : diff_w;
      end
      lis_pkg::OP_BLK_MUL: begin
        prod <= blk_prod_w[31:0];
      end
      lis_pkg::OP_BLK_BEG: begin
        res_beg <= first_r + prod + r0_min;
      end
      lis_pkg::OP_BLK_END: begin
        // Lower ranks take one of the leftover iterations each.
        res_end  <= res_beg + q + {31'b0, r0_lt};
        res_last <= 1'b1;
        res_stat <= lis_pkg::ST_OK;
      end
      lis_pkg::OP_NO_RANGE: begin
        res_beg  <= limit_r;
        res_end  <= limit_r;
        res_last <= 1'b1;
        res_stat <= lis_pkg::ST_NO_RANGE;
      end
      lis_pkg::OP_ZERO_CHUNK: begin
        res_beg  <= first_r;
        res_end  <= first_r;
        res_last <= 1'b1;
        res_stat <= lis_pkg::ST_ZERO;
      end
      lis_pkg::OP_CH_TOTAL: begin
        // Number of chunks, counting a final partial one.
        total <= {1'b0, q} + {32'b0, rem != 32'd0};
      end
      lis_pkg::OP_CH_CNT: begin
        if (cnt_w > 33'(MAX_RANGES)) begin
          cnt_r <= CNT_W'(MAX_RANGES);
          st_r  <= lis_pkg::ST_TRUNC;
        end else begin
          cnt_r <= cnt_w[CNT_W-1:0];
          st_r  <= lis_pkg::ST_OK;
        end
        off   <= {2'b0, {31'b0, r0} * {7'b0, chunk_r}};
        stepv <= {31'b0, n_eff} * {7'b0, chunk_r};
      end
      lis_pkg::OP_CH_RANGE: begin
        // The chunk that runs past the limit is clipped to it.
        res_beg  <= first_r + off[31:0];
        res_end  <= (end_off > {7'b0, span}) ? limit_r : first_r + end_off[31:0];
        res_last <= cnt_r == CNT_W'(1);
        res_stat <= st_r;
        off      <= off + {2'b0, stepv};
        cnt_r    <= cnt_r - 1'b1;
      end
      lis_pkg::OP_DYN_BEG: begin
        beg_r <= idx;
        span  <= {limit_r[31], limit_r} - {idx[31], idx};
      end
      lis_pkg::OP_DYN_SIZE: begin
        size_r <= {1'b0, chunk_r};
      end
      lis_pkg::OP_GD_SIZE: begin
        // Guided part is the remaining share, but never below the chunk size.
        size_r <= (q < {1'b0, chunk_r}) ? {1'b0, chunk_r} : q;
      end
      lis_pkg::OP_DYN_FIN: begin
        res_beg  <= beg_r;
        res_last <= 1'b1;
        if ($signed(beg_r) >= $signed(limit_r)) begin
          res_end  <= beg_r;
          res_stat <= lis_pkg::ST_NO_RANGE;
        end else begin
          res_end  <= ($signed(dyn_end) > $signed({{2{limit_r[31]}}, limit_r}))
                    ? limit_r : dyn_end[31:0];
          res_stat <= lis_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register. A result waits here while the sequencer moves on, and an emit
  // step stalls only while an earlier result has not yet been transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op == lis_pkg::OP_EMIT && !out_full) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == lis_pkg::OP_EMIT && !out_full) begin
      range_begin <= res_beg;
      range_end   <= res_end;
      last_range  <= res_last;
      status      <= res_stat;
    end
  end

endmodule
